// File: src/rvexe_pkg.sv
// Shared types and constants of the RV32I execute block.
package rvexe_pkg;

  localparam int XLEN          = 32;
  localparam int CMD_W         = 6;
  localparam int RIDX_W        = 5;
  localparam int NUM_REGS_DEF  = 32;
  localparam int MEM_WORDS_DEF = 1024;
  localparam int PC_STEP       = 4;
  localparam int LUI_SHIFT     = 12;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 6'd0, CMD_SUB, CMD_SLL, CMD_SLT, CMD_SLTU,
    CMD_XOR, CMD_SRL, CMD_SRA, CMD_OR, CMD_AND,
    CMD_ADDI, CMD_SLTI, CMD_SLTIU, CMD_XORI, CMD_ORI,
    CMD_ANDI, CMD_SLLI, CMD_SRLI, CMD_SRAI, CMD_LUI,
    CMD_LB, CMD_LH, CMD_LW, CMD_LBU, CMD_LHU,
    CMD_SB, CMD_SH, CMD_SW,
    CMD_JAL, CMD_JALR, CMD_BEQ, CMD_BNE, CMD_BLT,
    CMD_BGE, CMD_BLTU, CMD_BGEU
  } cmd_t;

  // Execute-stage result handed from the ALU to the pipeline.
  typedef struct packed {
    logic [XLEN-1:0] next_pc;
    logic            wr;
    logic            is_load;
    logic            is_store;
    logic [XLEN-1:0] val;
    logic [XLEN-1:0] maddr;
  } exe_t;

endpackage

// File: src/rvexe_regfile.sv
// Register file: synchronous RAM, two read ports, one write port, per-entry valid bits.
module rvexe_regfile #(
  parameter  int NUM_REGS = rvexe_pkg::NUM_REGS_DEF,
  localparam int AW       = $clog2(NUM_REGS)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [AW-1:0]              ra_addr,
  input  logic [AW-1:0]              rb_addr,
  output logic [rvexe_pkg::XLEN-1:0] ra_data,
  output logic [rvexe_pkg::XLEN-1:0] rb_data,
  input  logic                       we,
  input  logic [AW-1:0]              wa,
  input  logic [rvexe_pkg::XLEN-1:0] wd
);

  logic [rvexe_pkg::XLEN-1:0] mem [NUM_REGS];
  logic [NUM_REGS-1:0]        vld_r;
  logic [rvexe_pkg::XLEN-1:0] ra_q_r, rb_q_r;
  logic                       ra_v_r, rb_v_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    ra_q_r <= mem[ra_addr];
    rb_q_r <= mem[rb_addr];
    ra_v_r <= vld_r[ra_addr];
    rb_v_r <= vld_r[rb_addr];
  end

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[wa] <= 1'b1;
    end
  end

  assign ra_data = ra_v_r ? ra_q_r : '0;
  assign rb_data = rb_v_r ? rb_q_r : '0;

endmodule

// File: src/rvexe_dmem.sv
// Data memory: synchronous word RAM with a clearing pass after reset.
module rvexe_dmem #(
  parameter  int MEM_WORDS = rvexe_pkg::MEM_WORDS_DEF,
  localparam int AW        = $clog2(MEM_WORDS)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [AW-1:0]              rd_addr,
  output logic [rvexe_pkg::XLEN-1:0] rd_data,
  input  logic                       we,
  input  logic [AW-1:0]              wr_addr,
  input  logic [rvexe_pkg::XLEN-1:0] wr_data,
  output logic                       clr_busy
);

  logic [rvexe_pkg::XLEN-1:0] mem [MEM_WORDS];
  logic [rvexe_pkg::XLEN-1:0] rd_data_r;
  logic [AW-1:0]              clr_cnt_r, clr_cnt_nxt;
  logic                       clr_busy_r, clr_busy_nxt;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clr_busy_r) begin
      if (clr_cnt_r == AW'(MEM_WORDS - 1)) begin
        clr_busy_nxt = 1'b0;
      end else begin
        clr_cnt_nxt = AW'(clr_cnt_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

// File: src/rvexe_wmod.sv
// Word index = (byte address >> 2) mod MEM_WORDS, two stages via exact reciprocal.
module rvexe_wmod #(
  parameter  int MEM_WORDS = rvexe_pkg::MEM_WORDS_DEF,
  localparam int AW        = $clog2(MEM_WORDS)
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [rvexe_pkg::XLEN-3:0]   x,
  output logic [AW-1:0]                widx
);

  localparam int XW    = rvexe_pkg::XLEN - 2;
  localparam int PW    = XW + 32;
  localparam int SHIFT = XW + AW;
  localparam logic [63:0] RECIP =
    ((64'd1 << SHIFT) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS);

  logic [PW-1:0] prod;
  logic [XW-1:0] q_r, x_r;

  // quotient estimate is exact for every XW-bit x with this rounding
  assign prod = PW'(x) * PW'(RECIP[31:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= XW'(prod >> SHIFT);
      x_r <= x;
    end
  end

  assign widx = AW'(XW'(x_r - XW'(q_r * XW'(MEM_WORDS))));

endmodule

// File: src/rvexe_alu.sv
// Execute logic: ALU, address generation, branch resolution and next PC.
module rvexe_alu (
  input  logic [rvexe_pkg::CMD_W-1:0] cmd,
  input  logic [rvexe_pkg::XLEN-1:0]  pc,
  input  logic [rvexe_pkg::XLEN-1:0]  a,
  input  logic [rvexe_pkg::XLEN-1:0]  b,
  input  logic [rvexe_pkg::XLEN-1:0]  imm,
  input  logic [rvexe_pkg::XLEN-1:0]  tgt,
  output rvexe_pkg::exe_t             exe
);

  rvexe_pkg::cmd_t            op;
  logic [rvexe_pkg::XLEN-1:0] y, sum_ai, pc4;
  logic [4:0]                 sh;
  logic                       take;

  always_comb begin
    op     = rvexe_pkg::cmd_t'(cmd);
    y      = (op inside {[rvexe_pkg::CMD_ADD:rvexe_pkg::CMD_AND]}) ? b : imm;
    sh     = y[4:0];
    sum_ai = a + imm;
    pc4    = pc + rvexe_pkg::XLEN'(rvexe_pkg::PC_STEP);
    take   = 1'b0;
    exe         = '0;
    exe.next_pc = pc4;
    case (op)
      rvexe_pkg::CMD_ADD, rvexe_pkg::CMD_ADDI: begin
        exe.val = a + y; exe.wr = 1'b1;
      end
      rvexe_pkg::CMD_SUB: begin
        exe.val = a - y; exe.wr = 1'b1;
      end
      rvexe_pkg::CMD_SLL, rvexe_pkg::CMD_SLLI: begin
        exe.val = a << sh; exe.wr = 1'b1;
      end
      rvexe_pkg::CMD_SLT, rvexe_pkg::CMD_SLTI: begin
        exe.val = {31'd0, $signed(a) < $signed(y)}; exe.wr = 1'b1;
      end
      rvexe_pkg::CMD_SLTU, rvexe_pkg::CMD_SLTIU: begin
        exe.val = {31'd0, a < y}; exe.wr = 1'b1;
      end
      rvexe_pkg::CMD_XOR, rvexe_pkg::CMD_XORI: begin
        exe.val = a ^ y; exe.wr = 1'b1;
      end
      rvexe_pkg::CMD_SRL, rvexe_pkg::CMD_SRLI: begin
        exe.val = a >> sh; exe.wr = 1'b1;
      end
      rvexe_pkg::CMD_SRA, rvexe_pkg::CMD_SRAI: begin
        exe.val = $unsigned($signed(a) >>> sh); exe.wr = 1'b1;
      end
      rvexe_pkg::CMD_OR, rvexe_pkg::CMD_ORI: begin
        exe.val = a | y; exe.wr = 1'b1;
      end
      rvexe_pkg::CMD_AND, rvexe_pkg::CMD_ANDI: begin
        exe.val = a & y; exe.wr = 1'b1;
      end
      rvexe_pkg::CMD_LUI: begin
        exe.val = imm << rvexe_pkg::LUI_SHIFT; exe.wr = 1'b1;
      end
      rvexe_pkg::CMD_LB, rvexe_pkg::CMD_LH, rvexe_pkg::CMD_LW,
      rvexe_pkg::CMD_LBU, rvexe_pkg::CMD_LHU: begin
        exe.maddr = sum_ai; exe.is_load = 1'b1; exe.wr = 1'b1;
      end
      rvexe_pkg::CMD_SB, rvexe_pkg::CMD_SH, rvexe_pkg::CMD_SW: begin
        exe.maddr = sum_ai; exe.is_store = 1'b1;
      end
      rvexe_pkg::CMD_JAL: begin
        exe.val = pc4; exe.wr = 1'b1; exe.next_pc = tgt;
      end
      rvexe_pkg::CMD_JALR: begin
        exe.val = pc4; exe.wr = 1'b1; exe.next_pc = {sum_ai[31:1], 1'b0};
      end
      rvexe_pkg::CMD_BEQ, rvexe_pkg::CMD_BNE, rvexe_pkg::CMD_BLT,
      rvexe_pkg::CMD_BGE, rvexe_pkg::CMD_BLTU, rvexe_pkg::CMD_BGEU: begin
        case (op)
          rvexe_pkg::CMD_BEQ:  take = (a == b);
          rvexe_pkg::CMD_BNE:  take = (a != b);
          rvexe_pkg::CMD_BLT:  take = ($signed(a) < $signed(b));
          rvexe_pkg::CMD_BGE:  take = !($signed(a) < $signed(b));
          rvexe_pkg::CMD_BLTU: take = (a < b);
          default:             take = (a >= b);
        endcase
        exe.next_pc = take ? tgt : pc4;
      end
      default: ;  // undefined command: no-op
    endcase
  end

endmodule

// File: src/rvexe_lsu.sv
// Byte-lane load extraction and store merge on one memory word.
module rvexe_lsu (
  input  logic [rvexe_pkg::CMD_W-1:0] cmd,
  input  logic [1:0]                  lane,
  input  logic [rvexe_pkg::XLEN-1:0]  word,
  input  logic [rvexe_pkg::XLEN-1:0]  sdata,
  output logic [rvexe_pkg::XLEN-1:0]  ld_val,
  output logic [rvexe_pkg::XLEN-1:0]  st_word
);

  rvexe_pkg::cmd_t op;
  logic [7:0]      bsel;
  logic [15:0]     hsel;

  always_comb begin
    op      = rvexe_pkg::cmd_t'(cmd);
    bsel    = word[{lane, 3'b000} +: 8];
    hsel    = lane[1] ? word[31:16] : word[15:0];
    ld_val  = '0;
    st_word = word;
    case (op)
      rvexe_pkg::CMD_LB:  ld_val = {{24{bsel[7]}}, bsel};
      rvexe_pkg::CMD_LH:  ld_val = {{16{hsel[15]}}, hsel};
      rvexe_pkg::CMD_LW:  ld_val = word;
      rvexe_pkg::CMD_LBU: ld_val = {24'd0, bsel};
      rvexe_pkg::CMD_LHU: ld_val = {16'd0, hsel};
      rvexe_pkg::CMD_SB:  st_word[{lane, 3'b000} +: 8] = sdata[7:0];
      rvexe_pkg::CMD_SH: begin
        if (lane[1]) begin
          st_word[31:16] = sdata[15:0];
        end else begin
          st_word[15:0] = sdata[15:0];
        end
      end
      rvexe_pkg::CMD_SW:  st_word = sdata;
      default: ;
    endcase
  end

endmodule

// File: src/rv32i_decoded_instruction_execute.sv
// Flow: an accepted word passes S1, S2, S3 and S4 into the output register and stays on
//   the out_ ports until it is taken.
// Throughput: one word per cycle when nothing stalls; a source that depends on a load still
//   in flight holds the word in stage 1 until the load commits.
// Reset: registers, PC and valid bits clear at once; the data memory is then swept to zero
//   one word per cycle, with in_ready low until the sweep ends.
module rv32i_decoded_instruction_execute #(
  parameter  int NUM_REGS  = rvexe_pkg::NUM_REGS_DEF,
  parameter  int MEM_WORDS = rvexe_pkg::MEM_WORDS_DEF,
  localparam int RAW       = $clog2(NUM_REGS),
  localparam int MAW       = $clog2(MEM_WORDS)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [rvexe_pkg::CMD_W-1:0]        in_command,
  input  logic [rvexe_pkg::RIDX_W-1:0]       in_dest_reg,
  input  logic [rvexe_pkg::RIDX_W-1:0]       in_src_reg_a,
  input  logic [rvexe_pkg::RIDX_W-1:0]       in_src_reg_b,
  input  logic signed [rvexe_pkg::XLEN-1:0]  in_immediate,
  input  logic [rvexe_pkg::XLEN-1:0]         in_branch_target,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rvexe_pkg::XLEN-1:0]         out_next_pc,
  output logic                               out_reg_write_enable,
  output logic [rvexe_pkg::RIDX_W-1:0]       out_reg_write_index,
  output logic [rvexe_pkg::XLEN-1:0]         out_reg_write_value,
  output logic                               out_mem_write_enable,
  output logic [rvexe_pkg::XLEN-1:0]         out_mem_address
);

  localparam int XLEN = rvexe_pkg::XLEN;
  localparam int RW   = rvexe_pkg::RIDX_W;
  localparam int CW   = rvexe_pkg::CMD_W;

  // Pipeline:
  //   S1  register file read data arrives; forwarding; ALU / AGU / branch; PC update
  //   S2  word index, reciprocal multiply
  //   S3  word index remainder; data memory read issued
  //   S4  memory word arrives; load extract / store merge; commit to RF and memory
  //   OUT output register, holds the result word until taken
  // The whole pipe moves when OUT can take a word; S1 alone holds on a load-use hazard.

  logic pipe_go, in_acc, hazard, s1_adv, s1_hold, clr_busy;

  // ---------------- S1 ----------------
  logic                s1_valid_r;
  logic [CW-1:0]       s1_cmd_r;
  logic [RW-1:0]       s1_rd_r, s1_ra_r, s1_rb_r;
  logic [XLEN-1:0]     s1_imm_r, s1_tgt_r;
  logic [XLEN-1:0]     pc_r;

  logic [RAW-1:0]      rf_ra_addr, rf_rb_addr;
  logic [XLEN-1:0]     rf_ra_data, rf_rb_data;
  logic                rf_we;

  logic [RW-1:0]       src_idx [2];
  logic [XLEN-1:0]     ram_val [2];
  logic [XLEN-1:0]     opv     [2];
  logic                stl     [2];

  rvexe_pkg::exe_t     exe, s1_exe;
  logic                dest_ok;

  // ---------------- S2..S4 ----------------
  logic                s2_valid_r, s3_valid_r, s4_valid_r;
  logic [CW-1:0]       s2_cmd_r, s3_cmd_r, s4_cmd_r;
  logic [RW-1:0]       s2_rd_r, s3_rd_r, s4_rd_r;
  rvexe_pkg::exe_t     s2_exe_r, s3_exe_r, s4_exe_r;
  logic [XLEN-1:0]     s2_sdata_r, s3_sdata_r, s4_sdata_r;
  logic [MAW-1:0]      s3_widx, s4_widx_r;

  logic [MAW-1:0]      dmem_raddr;
  logic [XLEN-1:0]     dmem_rdata, s4_word, ld_val, st_word, s4_val;
  logic                dmem_we;

  // last committed writes, covering reads issued at the same edge
  logic                lwr_v_r, lwm_v_r;
  logic [RW-1:0]       lwr_idx_r;
  logic [XLEN-1:0]     lwr_val_r, lwm_data_r;
  logic [MAW-1:0]      lwm_addr_r;

  // ---------------- OUT ----------------
  logic                out_valid_r, out_rwe_r, out_mwe_r;
  logic [XLEN-1:0]     out_pc_r, out_rval_r, out_maddr_r;
  logic [RW-1:0]       out_ridx_r;

  // ---------------- handshake ----------------
  assign pipe_go  = !out_valid_r || out_ready;
  assign hazard   = stl[0] || stl[1];
  assign s1_adv   = pipe_go && s1_valid_r && !hazard;
  assign s1_hold  = s1_valid_r && !s1_adv;
  assign in_ready = pipe_go && !(s1_valid_r && hazard) && !clr_busy;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r <= in_command;
      s1_rd_r  <= in_dest_reg;
      s1_ra_r  <= in_src_reg_a;
      s1_rb_r  <= in_src_reg_b;
      s1_imm_r <= $unsigned(in_immediate);
      s1_tgt_r <= in_branch_target;
    end
  end

  // re-read while S1 holds so the RAM data stays current
  assign rf_ra_addr = s1_hold ? s1_ra_r[RAW-1:0] : in_src_reg_a[RAW-1:0];
  assign rf_rb_addr = s1_hold ? s1_rb_r[RAW-1:0] : in_src_reg_b[RAW-1:0];

  rvexe_regfile #(.NUM_REGS(NUM_REGS)) u_rf (
    .clk     (clk),
    .rst_n   (rst_n),
    .ra_addr (rf_ra_addr),
    .rb_addr (rf_rb_addr),
    .ra_data (rf_ra_data),
    .rb_data (rf_rb_data),
    .we      (rf_we),
    .wa      (s4_rd_r[RAW-1:0]),
    .wd      (s4_val)
  );

  assign src_idx[0] = s1_ra_r;
  assign src_idx[1] = s1_rb_r;
  assign ram_val[0] = rf_ra_data;
  assign ram_val[1] = rf_rb_data;

  // Forwarding, oldest first so the youngest writer wins. A pending load has no value
  // yet: that marks a stall, cleared again if a younger non-load writer overrides it.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      opv[k] = ram_val[k];
      stl[k] = 1'b0;
      if (lwr_v_r && lwr_idx_r == src_idx[k]) begin
        opv[k] = lwr_val_r;
      end
      if (s4_valid_r && s4_exe_r.wr && s4_rd_r == src_idx[k]) begin
        opv[k] = s4_exe_r.val;
        stl[k] = s4_exe_r.is_load;
      end
      if (s3_valid_r && s3_exe_r.wr && s3_rd_r == src_idx[k]) begin
        opv[k] = s3_exe_r.val;
        stl[k] = s3_exe_r.is_load;
      end
      if (s2_valid_r && s2_exe_r.wr && s2_rd_r == src_idx[k]) begin
        opv[k] = s2_exe_r.val;
        stl[k] = s2_exe_r.is_load;
      end
      // x0 and indexes past the file read as zero
      if (src_idx[k] == '0 || int'(src_idx[k]) >= NUM_REGS) begin
        opv[k] = '0;
        stl[k] = 1'b0;
      end
      if (!s1_valid_r) begin
        stl[k] = 1'b0;
      end
    end
  end

  rvexe_alu u_alu (
    .cmd (s1_cmd_r),
    .pc  (pc_r),
    .a   (opv[0]),
    .b   (opv[1]),
    .imm (s1_imm_r),
    .tgt (s1_tgt_r),
    .exe (exe)
  );

  // writes to x0 or past the file are dropped
  assign dest_ok = (s1_rd_r != '0) && (int'(s1_rd_r) < NUM_REGS);

  always_comb begin
    s1_exe    = exe;
    s1_exe.wr = exe.wr && dest_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else if (s1_adv) begin
      pc_r <= exe.next_pc;
    end
  end

  // ---------------- stage shift ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (pipe_go) begin
      s2_valid_r  <= s1_adv;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_go) begin
      s2_cmd_r   <= s1_cmd_r;
      s2_rd_r    <= s1_rd_r;
      s2_exe_r   <= s1_exe;
      s2_sdata_r <= opv[1];
      s3_cmd_r   <= s2_cmd_r;
      s3_rd_r    <= s2_rd_r;
      s3_exe_r   <= s2_exe_r;
      s3_sdata_r <= s2_sdata_r;
      s4_cmd_r   <= s3_cmd_r;
      s4_rd_r    <= s3_rd_r;
      s4_exe_r   <= s3_exe_r;
      s4_sdata_r <= s3_sdata_r;
      s4_widx_r  <= s3_widx;
    end
  end

  rvexe_wmod #(.MEM_WORDS(MEM_WORDS)) u_wmod (
    .clk  (clk),
    .en   (pipe_go),
    .x    (s2_exe_r.maddr[XLEN-1:2]),
    .widx (s3_widx)
  );

  // ---------------- data memory ----------------
  assign dmem_raddr = pipe_go ? s3_widx : s4_widx_r;
  assign dmem_we    = pipe_go && s4_valid_r && s4_exe_r.is_store;

  rvexe_dmem #(.MEM_WORDS(MEM_WORDS)) u_dmem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (dmem_raddr),
    .rd_data  (dmem_rdata),
    .we       (dmem_we),
    .wr_addr  (s4_widx_r),
    .wr_data  (st_word),
    .clr_busy (clr_busy)
  );

  // a store committed at the edge that issued this read is not in the RAM data
  assign s4_word = (lwm_v_r && lwm_addr_r == s4_widx_r) ? lwm_data_r : dmem_rdata;

  rvexe_lsu u_lsu (
    .cmd     (s4_cmd_r),
    .lane    (s4_exe_r.maddr[1:0]),
    .word    (s4_word),
    .sdata   (s4_sdata_r),
    .ld_val  (ld_val),
    .st_word (st_word)
  );

  assign s4_val = s4_exe_r.is_load ? ld_val : s4_exe_r.val;
  assign rf_we  = pipe_go && s4_valid_r && s4_exe_r.wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lwr_v_r <= 1'b0;
      lwm_v_r <= 1'b0;
    end else begin
      lwr_v_r <= rf_we;
      lwm_v_r <= dmem_we;
    end
  end

  always_ff @(posedge clk) begin
    lwr_idx_r  <= s4_rd_r;
    lwr_val_r  <= s4_val;
    lwm_addr_r <= s4_widx_r;
    lwm_data_r <= st_word;
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (pipe_go) begin
      out_pc_r    <= s4_exe_r.next_pc;
      out_rwe_r   <= s4_exe_r.wr;
      out_ridx_r  <= s4_exe_r.wr ? s4_rd_r : '0;
      out_rval_r  <= s4_exe_r.wr ? s4_val : '0;
      out_mwe_r   <= s4_exe_r.is_store;
      out_maddr_r <= s4_exe_r.maddr;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_next_pc          = out_pc_r;
  assign out_reg_write_enable = out_rwe_r;
  assign out_reg_write_index  = out_ridx_r;
  assign out_reg_write_value  = out_rval_r;
  assign out_mem_write_enable = out_mwe_r;
  assign out_mem_address      = out_maddr_r;

endmodule
